/* hw/rtl/lrs_pkg.sv */
// shared types and constants for the line rasterizer stepper
package lrs_pkg;

	localparam int COORD_BITS = 12;
	localparam int DELTA_BITS = COORD_BITS + 2;
	localparam int ERROR_BITS = COORD_BITS + 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   wide_coord_t;
	typedef logic        [COORD_BITS-1:0] span_t;
	typedef logic        [DELTA_BITS-1:0] delta_t;
	typedef logic signed [ERROR_BITS-1:0] error_t;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_STEP = 1'b1
	} func_t;

	typedef struct packed {
		logic   active;
		logic   steep;
		coord_t major_pos;
		coord_t major_end;
		coord_t minor_pos;
		logic   minor_dir_down;
		error_t error_term;
		delta_t twice_major_delta;
		delta_t twice_minor_delta;
	} line_state_t;

	typedef struct packed {
		logic   valid;
		coord_t x;
		coord_t y;
		logic   last;
	} pixel_t;

endpackage

/* hw/rtl/line_rasterizer_stepper.sv */
// top level of the line rasterizer stepper
// Bresenham line stepper. A load transaction (func = 0) sets up a line from two signed
// endpoints and produces no output; each step transaction (func = 1) produces one output
// transaction carrying the next pixel, with last_pixel marking the final one and the far
// endpoint excluded. A step with no line in progress returns pixel_valid = 0 and zero
// coordinates. Line setup is a short subtract/compare path from the input ports into the line state
// register, and the error update a single add/compare path from that register back into it, with
// the pixel going into the output register, so with out_ready held high one transaction is
// accepted every clock and each result appears in the cycle after its step.
// in_ready drops only while an unconsumed result sits in the output register.
module line_rasterizer_stepper (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            func,
	input  lrs_pkg::coord_t start_x,
	input  lrs_pkg::coord_t start_y,
	input  lrs_pkg::coord_t end_x,
	input  lrs_pkg::coord_t end_y,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            pixel_valid,
	output lrs_pkg::coord_t pixel_x,
	output lrs_pkg::coord_t pixel_y,
	output logic            last_pixel
);
	import lrs_pkg::*;

	line_state_t state_q;
	line_state_t state_d;
	line_state_t setup_state;
	line_state_t step_state;
	pixel_t      step_pixel;
	pixel_t      pixel_q;
	logic        out_valid_q;
	logic        accept;
	logic        accept_load;
	logic        accept_step;

	lrs_setup u_setup (
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.line_state (setup_state)
	);

	lrs_step u_step (
		.cur   (state_q),
		.nxt   (step_state),
		.pixel (step_pixel)
	);

	assign in_ready    = !out_valid_q || out_ready;
	assign accept      = in_valid && in_ready;
	assign accept_load = accept && (func == FUNC_LOAD);
	assign accept_step = accept && (func == FUNC_STEP);

	always_comb begin
		state_d = state_q;
		if (accept_load) begin
			state_d = setup_state;
		end else if (accept_step) begin
			state_d = step_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_step) begin
			pixel_q <= step_pixel;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_valid = pixel_q.valid;
	assign pixel_x     = pixel_q.x;
	assign pixel_y     = pixel_q.y;
	assign last_pixel  = pixel_q.last;

endmodule

/* hw/rtl/lrs_setup.sv */
// line setup: steepness, axis swap, endpoint ordering and delta terms
module lrs_setup (
	input  lrs_pkg::coord_t      start_x,
	input  lrs_pkg::coord_t      start_y,
	input  lrs_pkg::coord_t      end_x,
	input  lrs_pkg::coord_t      end_y,
	output lrs_pkg::line_state_t line_state
);
	import lrs_pkg::*;

	wide_coord_t diff_x;
	wide_coord_t diff_y;
	span_t       abs_x;
	span_t       abs_y;
	logic        steep;
	coord_t      p1_major;
	coord_t      p1_minor;
	coord_t      p2_major;
	coord_t      p2_minor;
	logic        swap_ends;
	coord_t      lo_major;
	coord_t      hi_major;
	coord_t      lo_minor;
	coord_t      hi_minor;
	span_t       major_span;
	span_t       minor_span;

	assign diff_x = wide_coord_t'(end_x) - wide_coord_t'(start_x);
	assign diff_y = wide_coord_t'(end_y) - wide_coord_t'(start_y);
	assign abs_x  = diff_x[COORD_BITS] ? span_t'(-diff_x) : span_t'(diff_x);
	assign abs_y  = diff_y[COORD_BITS] ? span_t'(-diff_y) : span_t'(diff_y);
	assign steep  = abs_y > abs_x;

	assign p1_major = steep ? start_y : start_x;
	assign p1_minor = steep ? start_x : start_y;
	assign p2_major = steep ? end_y : end_x;
	assign p2_minor = steep ? end_x : end_y;

	assign swap_ends = p1_major > p2_major;
	assign lo_major  = swap_ends ? p2_major : p1_major;
	assign hi_major  = swap_ends ? p1_major : p2_major;
	assign lo_minor  = swap_ends ? p2_minor : p1_minor;
	assign hi_minor  = swap_ends ? p1_minor : p2_minor;

	assign major_span = steep ? abs_y : abs_x;
	assign minor_span = steep ? abs_x : abs_y;

	always_comb begin
		line_state.active            = major_span != '0;
		line_state.steep             = steep;
		line_state.major_pos         = lo_major;
		line_state.major_end         = hi_major;
		line_state.minor_pos         = lo_minor;
		line_state.minor_dir_down    = !(lo_minor < hi_minor);
		line_state.error_term        = error_t'({1'b0, major_span});
		line_state.twice_major_delta = {1'b0, major_span, 1'b0};
		line_state.twice_minor_delta = {1'b0, minor_span, 1'b0};
	end

endmodule

/* hw/rtl/lrs_step.sv */
// one pixel step: emits the current pixel and advances the doubled error term
module lrs_step (
	input  lrs_pkg::line_state_t cur,
	output lrs_pkg::line_state_t nxt,
	output lrs_pkg::pixel_t      pixel
);
	import lrs_pkg::*;

	error_t      err_sub;
	logic        carry;
	wide_coord_t major_inc;
	wide_coord_t major_lim;
	logic        last;

	assign err_sub   = cur.error_term - error_t'({1'b0, cur.twice_minor_delta});
	assign carry     = err_sub[ERROR_BITS-1];
	assign major_inc = wide_coord_t'(cur.major_pos) + wide_coord_t'(1);
	assign major_lim = wide_coord_t'(cur.major_end);
	assign last      = major_inc == major_lim;

	always_comb begin
		nxt = cur;
		pixel = '0;
		if (cur.active) begin
			pixel.valid = 1'b1;
			pixel.x     = cur.steep ? cur.minor_pos : cur.major_pos;
			pixel.y     = cur.steep ? cur.major_pos : cur.minor_pos;
			pixel.last  = last;
			nxt.error_term = carry ?
				err_sub + error_t'({1'b0, cur.twice_major_delta}) : err_sub;
			if (carry) begin
				nxt.minor_pos = cur.minor_dir_down ?
					cur.minor_pos - coord_t'(1) : cur.minor_pos + coord_t'(1);
			end
			nxt.major_pos = coord_t'(major_inc);
			nxt.active    = major_inc < major_lim;
		end
	end

endmodule

/* hw/rtl/lrs_checker.sv */
// port-level assertions for the line rasterizer stepper and their bind
module lrs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            func,
	input logic            out_valid,
	input logic            out_ready,
	input logic            pixel_valid,
	input lrs_pkg::coord_t pixel_x,
	input lrs_pkg::coord_t pixel_y,
	input logic            last_pixel
);
	import lrs_pkg::*;

	// a load transaction never produces output
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_LOAD) |=> !out_valid)
		else $error("load produced an output transaction");

	// every step transaction produces output in the next cycle
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_STEP) |=> out_valid)
		else $error("step produced no output transaction");

	// idle steps carry zero fields
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> (pixel_x == '0) && (pixel_y == '0) && !last_pixel)
		else $error("idle step with non-zero fields");

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
		else $error("stalled output changed");

	// input side accepts whenever the output slot can take a result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output empty");

endmodule

bind line_rasterizer_stepper lrs_checker u_lrs_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for the line rasterizer stepper
module tb_top;
	import lrs_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_CYCLES  = 60;
	localparam int RANDOM_ITEMS = 1900;
	localparam int HOLD_AT      = 500;
	localparam int PAUSE_AT     = 1000;
	localparam int QUIET_FROM   = 1650;

	typedef struct packed {
		func_t  func;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		logic   typed;
		pixel_t px;
	} row_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	logic   func;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	logic   out_valid;
	logic   out_ready;
	logic   pixel_valid;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last_pixel;

	line_rasterizer_stepper dut (.*);

	// line state as the stepper should hold it
	logic   line_active;
	logic   line_steep;
	logic   line_down;
	coord_t line_major;
	coord_t line_end;
	coord_t line_minor;
	error_t line_err;
	delta_t line_twice_major;
	delta_t line_twice_minor;

	pixel_t expected_pixels[$];
	pixel_t want;
	int     mismatches;
	int     items_sent;
	int     idle_cycles;
	int     calm_left;
	bit     quiet_tail;
	bit     hold_pending;

	row_t directed_rows [27] = '{
		'{FUNC_STEP, 0, 0, 0, 0, 1'b1, '{1'b0, 0, 0, 1'b0}},
		'{FUNC_LOAD, -2048, -2048, 2047, -2048, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b1, '{1'b1, -2048, -2048, 1'b0}},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_LOAD, 5, 5, 5, 5, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b1, '{1'b0, 0, 0, 1'b0}},
		'{FUNC_LOAD, 2047, 2047, 2046, 2047, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b1, '{1'b1, 2046, 2047, 1'b1}},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b1, '{1'b0, 0, 0, 1'b0}},
		'{FUNC_LOAD, -2048, 2047, 2047, -2048, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b1, '{1'b1, -2048, 2047, 1'b0}},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_LOAD, 0, -2048, 1, 2047, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b1, '{1'b1, 0, -2048, 1'b0}},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_LOAD, 3, 10, -2, -7, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_LOAD, -7, 9, 4, 9, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_LOAD, 0, 0, 3, 3, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0},
		'{FUNC_STEP, 0, 0, 0, 0, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int span_of(input int a, input int b);
		return a > b ? a - b : b - a;
	endfunction

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'(int'($urandom_range(0, 15)) - 2048);
			1: return coord_t'(2047 - int'($urandom_range(0, 15)));
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic coord_t nudge(input coord_t c);
		int v;
		v = int'(c) + int'($urandom_range(0, 40)) - 20;
		if (v < -2048)
			v = -2048;
		if (v > 2047)
			v = 2047;
		return coord_t'(v);
	endfunction

	// bresenham walk with the doubled error term
	task automatic trace_line(input row_t r);
		int a1, b1, a2, b2, t, err;
		pixel_t px;
		if (r.func == FUNC_LOAD) begin
			a1 = r.sx;
			b1 = r.sy;
			a2 = r.ex;
			b2 = r.ey;
			line_steep = span_of(b2, b1) > span_of(a2, a1);
			if (line_steep) begin
				t = a1; a1 = b1; b1 = t;
				t = a2; a2 = b2; b2 = t;
			end
			if (a1 > a2) begin
				t = a1; a1 = a2; a2 = t;
				t = b1; b1 = b2; b2 = t;
			end
			line_major       = coord_t'(a1);
			line_end         = coord_t'(a2);
			line_minor       = coord_t'(b1);
			line_down        = !(b1 < b2);
			line_err         = error_t'(a2 - a1);
			line_twice_major = delta_t'(2 * (a2 - a1));
			line_twice_minor = delta_t'(2 * span_of(b2, b1));
			line_active      = a1 < a2;
		end else begin
			px = '0;
			if (line_active) begin
				px.valid = 1'b1;
				px.x     = line_steep ? line_minor : line_major;
				px.y     = line_steep ? line_major : line_minor;
				px.last  = (int'(line_major) + 1 == int'(line_end));
				err = int'(line_err) - int'(line_twice_minor);
				if (err < 0) begin
					line_minor = line_down ? line_minor - 1'b1 : line_minor + 1'b1;
					err = err + int'(line_twice_major);
				end
				line_err   = error_t'(err);
				line_major = line_major + 1'b1;
				if (int'(line_major) >= int'(line_end))
					line_active = 1'b0;
			end
			expected_pixels.insert(expected_pixels.size(), r.typed ? r.px : px);
		end
	endtask

	task automatic offer(input row_t r);
		in_valid <= 1'b1;
		func     <= r.func;
		start_x  <= r.sx;
		start_y  <= r.sy;
		end_x    <= r.ex;
		end_y    <= r.ey;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		trace_line(r);
		items_sent++;
		if (calm_left > 0) begin
			calm_left--;
		end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
			calm_left = $urandom_range(20, 60);
		end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(posedge clk);
		end
	endtask

	task automatic report_mismatch(input string what, input int want_v, input int got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
	endtask

	initial begin
		row_t   r;
		int     kind, nsteps, len, len_b;
		coord_t ax, ay, bx, by;
		bit     paused, hold_done;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		func             = FUNC_LOAD;
		start_x          = '0;
		start_y          = '0;
		end_x            = '0;
		end_y            = '0;
		out_ready        = 1'b0;
		line_active      = 1'b0;
		line_steep       = 1'b0;
		line_down        = 1'b0;
		line_major       = '0;
		line_end         = '0;
		line_minor       = '0;
		line_err         = '0;
		line_twice_major = '0;
		line_twice_minor = '0;
		mismatches       = 0;
		items_sent       = 0;
		calm_left        = 0;
		quiet_tail       = 1'b0;
		hold_pending     = 1'b0;
		paused           = 1'b0;
		hold_done        = 1'b0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer(directed_rows[i]);

		while (items_sent < RANDOM_ITEMS + $size(directed_rows)) begin
			if (items_sent >= QUIET_FROM)
				quiet_tail = 1'b1;
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done    = 1'b1;
				hold_pending = 1'b1;
				calm_left    = 80;
			end
			if (!paused && items_sent >= PAUSE_AT) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_pixels.size() != 0)
					@(posedge clk);
			end
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				ax = pick_coord();
				ay = pick_coord();
				if (kind == 7) begin
					bx = coord_t'($urandom);
					by = coord_t'($urandom);
				end else begin
					bx = nudge(ax);
					by = nudge(ay);
				end
				offer(row_t'{FUNC_LOAD, ax, ay, bx, by, 1'b0, pixel_t'('0)});
				len   = span_of(bx, ax);
				len_b = span_of(by, ay);
				if (len_b > len)
					len = len_b;
				if (kind == 7)
					nsteps = $urandom_range(0, 40);
				else if ($urandom_range(0, 4) == 0)
					nsteps = $urandom_range(0, len);
				else
					nsteps = len + $urandom_range(0, 2);
				repeat (nsteps) begin
					r = row_t'{FUNC_STEP, coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom), 1'b0, pixel_t'('0)};
					offer(r);
				end
			end else begin
				r = row_t'{func_t'($urandom_range(0, 1)), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					1'b0, pixel_t'('0)};
				offer(r);
			end
		end

		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// result side back-pressure
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else if (quiet_tail) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
				repeat (n)
					@(posedge clk);
				if ($urandom_range(0, 2) == 0) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(1, 7))
						@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("unexpected transaction", 0, 1);
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_valid !== want.valid)
					report_mismatch("pixel_valid", want.valid, pixel_valid);
				if (pixel_x !== want.x)
					report_mismatch("pixel_x", want.x, pixel_x);
				if (pixel_y !== want.y)
					report_mismatch("pixel_y", want.y, pixel_y);
				if (last_pixel !== want.last)
					report_mismatch("last_pixel", want.last, last_pixel);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
